[design/nir_pkg.sv]
// ----------------------------------------------------------------------------
// nir_pkg
// Shared types and constants for the NEC infrared frame receiver.
// ----------------------------------------------------------------------------
package nir_pkg;

   // number of data bits in one frame
   localparam int CODE_BITS = 32;

   localparam int CODE_W    = 32;
   localparam int TICK_W    = 16;
   localparam int CNT_W     = $clog2(CODE_BITS + 1);
   localparam int SHIFT_W   = (CODE_BITS > CODE_W) ? CODE_BITS : CODE_W;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_LEADER_MIN = 2'd0;
   localparam logic [1:0] REG_LEADER_MAX = 2'd1;
   localparam logic [1:0] REG_ONE_SPACE  = 2'd2;

   localparam logic [TICK_W-1:0] LEADER_MIN_RST = 16'd1840;
   localparam logic [TICK_W-1:0] LEADER_MAX_RST = 16'd2640;
   localparam logic [TICK_W-1:0] ONE_SPACE_RST  = 16'd330;

   // event kinds
   localparam logic CMD_EDGE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_LEADER    = 2'd1,
      PH_FIRST_BIT = 2'd2,
      PH_RECEIVING = 2'd3
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] leader_min_ticks;
      logic [TICK_W-1:0] leader_max_ticks;
      logic [TICK_W-1:0] one_space_ticks;
   } cfg_type;

   typedef struct packed {
      logic              command;
      logic              falling_edge;
      logic [TICK_W-1:0] interval_ticks;
   } event_type;

endpackage

[design/nec_ir_frame_receiver_unit.sv]
// ----------------------------------------------------------------------------
// nec_ir_frame_receiver_unit
// NEC infrared frame receiver: decodes edge and timeout events into codes.
// ----------------------------------------------------------------------------
// Datapath: an accepted event passes the input register, then the decode
//   step writes its result into the result register.
// Throughput: one event per cycle; the input stage holds only while a
//   finished result is stalled at the output.
// Reset: synchronous; clears the phase, bit count, shift word and both valid
//   flags and loads the default leader window and one-bit threshold.
module nec_ir_frame_receiver_unit (
   input  logic                             clock,
   input  logic                             reset,
   // event channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic                             req_falling_edge,
   input  logic [nir_pkg::TICK_W-1:0]       req_interval_ticks,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [nir_pkg::CODE_W-1:0]       rsp_code_word,
   output logic                             rsp_is_repeat,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [nir_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [nir_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [nir_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import nir_pkg::*;

   cfg_type   cfg;
   event_type evt_ff, evt_in;
   logic      evt_valid_ff, evt_valid_in;
   logic      evt_ready;

   nir_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register: reloads whenever the decode step takes its transaction
   assign req_stall    = evt_valid_ff && !evt_ready;
   assign evt_valid_in = req_stall ? evt_valid_ff : req_valid;

   always_comb begin
      evt_in = evt_ff;
      if (!req_stall) begin
         evt_in.command        = req_command;
         evt_in.falling_edge   = req_falling_edge;
         evt_in.interval_ticks = req_interval_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
      end else begin
         evt_valid_ff <= evt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      evt_ff <= evt_in;
   end

   nir_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .evt_valid     (evt_valid_ff),
      .evt           (evt_ff),
      .evt_ready     (evt_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_word (rsp_code_word),
      .rsp_is_repeat (rsp_is_repeat)
   );

   // input side only backs up behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // an accepted transaction lands in the input register
   a_capture: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> evt_valid_ff)
      else $error("accepted transaction not captured");

   // a repeat marker never carries a code
   a_repeat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_repeat) |-> (rsp_code_word == '0))
      else $error("repeat marker with nonzero code");

   // a result only appears after a decode step consumed an event
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(evt_valid_ff))
      else $error("result without a consumed event");

endmodule

[design/nir_csr.sv]
// ----------------------------------------------------------------------------
// nir_csr
// APB register bank holding the leader window and the one-bit threshold.
// ----------------------------------------------------------------------------
module nir_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [nir_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [nir_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [nir_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output nir_pkg::cfg_type                 cfg
);
   import nir_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_LEADER_MIN: cfg_in.leader_min_ticks = csr_pwdata[TICK_W-1:0];
            REG_LEADER_MAX: cfg_in.leader_max_ticks = csr_pwdata[TICK_W-1:0];
            REG_ONE_SPACE:  cfg_in.one_space_ticks  = csr_pwdata[TICK_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_min_ticks <= LEADER_MIN_RST;
         cfg_ff.leader_max_ticks <= LEADER_MAX_RST;
         cfg_ff.one_space_ticks  <= ONE_SPACE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LEADER_MIN: csr_prdata = CSR_DATA_W'(cfg_ff.leader_min_ticks);
         REG_LEADER_MAX: csr_prdata = CSR_DATA_W'(cfg_ff.leader_max_ticks);
         REG_ONE_SPACE:  csr_prdata = CSR_DATA_W'(cfg_ff.one_space_ticks);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[design/nir_decode.sv]
// ----------------------------------------------------------------------------
// nir_decode
// Frame state machine, bit shifter and result register.
// ----------------------------------------------------------------------------
module nir_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  nir_pkg::cfg_type             cfg,
   input  logic                         evt_valid,
   input  nir_pkg::event_type           evt,
   output logic                         evt_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [nir_pkg::CODE_W-1:0]   rsp_code_word,
   output logic                         rsp_is_repeat
);
   import nir_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [CNT_W-1:0]    bit_count_ff, bit_count_in;
   logic [SHIFT_W-1:0]  shift_ff, shift_in;
   logic                out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]   out_code_ff, out_code_in;
   logic                out_rep_ff, out_rep_in;

   logic                step;
   logic                is_timeout;
   logic                in_window;
   logic                bit_val;
   logic [CNT_W-1:0]    count_inc;
   logic [SHIFT_W-1:0]  shift_next;
   logic                word_done;
   logic                emit;
   logic                emit_repeat;

   assign evt_ready  = !out_valid_ff || !rsp_stall;
   assign step       = evt_valid && evt_ready;
   assign is_timeout = (evt.command == CMD_TIMEOUT);
   assign in_window  = (evt.interval_ticks > cfg.leader_min_ticks) &&
                       (evt.interval_ticks < cfg.leader_max_ticks);
   assign bit_val    = (evt.interval_ticks > cfg.one_space_ticks);
   assign count_inc  = bit_count_ff + CNT_W'(1);
   assign shift_next = {shift_ff[SHIFT_W-2:0], bit_val};
   assign word_done  = (count_inc >= CNT_W'(CODE_BITS));

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (is_timeout) begin
            phase_in = PH_IDLE;
         end else begin
            case (phase_ff)
               PH_IDLE:      if (evt.falling_edge) phase_in = PH_LEADER;
               PH_LEADER:    if (in_window) phase_in = PH_FIRST_BIT;
               PH_FIRST_BIT: phase_in = PH_RECEIVING;
               PH_RECEIVING: if (evt.falling_edge && word_done) phase_in = PH_IDLE;
               default:      phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // datapath and results
   always_comb begin
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      emit         = 1'b0;
      emit_repeat  = 1'b0;
      if (step) begin
         if (is_timeout) begin
            if (phase_ff == PH_RECEIVING && bit_count_ff == '0) begin
               emit        = 1'b1;
               emit_repeat = 1'b1;
            end
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (evt.falling_edge) begin
                     bit_count_in = '0;
                     shift_in     = '0;
                  end
               end
               PH_RECEIVING: begin
                  if (evt.falling_edge) begin
                     bit_count_in = count_inc;
                     shift_in     = shift_next;
                     emit         = word_done;
                  end
               end
               default: begin
                  bit_count_in = bit_count_ff;
               end
            endcase
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_code_in  = out_code_ff;
      out_rep_in   = out_rep_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_rep_in   = emit_repeat;
         out_code_in  = emit_repeat ? '0 : shift_next[CODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_code_ff <= out_code_in;
      out_rep_ff  <= out_rep_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_code_word = out_code_ff;
   assign rsp_is_repeat = out_rep_ff;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the NEC infrared frame receiver. Drives edge and timeout
// events, programs the leader window and one-bit threshold over the register
// port, and checks every code and repeat marker against a cycle-free decoder
// model kept in step with each accepted event transaction.
// ----------------------------------------------------------------------------
module tb;
   import nir_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int DRAIN_LIMIT = 50000;

   typedef struct packed {
      logic [CODE_W-1:0] code_word;
      logic              is_repeat;
   } ir_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_command = 1'b0;
   logic                  req_falling_edge = 1'b0;
   logic [TICK_W-1:0]     req_interval_ticks = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CODE_W-1:0]     rsp_code_word;
   logic                  rsp_is_repeat;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // decoder model state and its copy of the registers
   logic [TICK_W-1:0]  cfg_leader_min = LEADER_MIN_RST;
   logic [TICK_W-1:0]  cfg_leader_max = LEADER_MAX_RST;
   logic [TICK_W-1:0]  cfg_one_space  = ONE_SPACE_RST;
   phase_type          ir_phase = PH_IDLE;
   logic [CNT_W-1:0]   ir_bit_count = '0;
   logic [SHIFT_W-1:0] ir_shift = '0;

   ir_result_type expected_codes[$];
   int mismatch_count = 0;
   int events_applied = 0;
   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   int rsp_hold_req = 0;
   int rsp_hold_left = 0;

   nec_ir_frame_receiver_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_falling_edge   (req_falling_edge),
      .req_interval_ticks (req_interval_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_code_word      (rsp_code_word),
      .rsp_is_repeat      (rsp_is_repeat),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #10 clock = ~clock;

   initial begin
      #(5_000_000);
      $display("FAILURE");
      $finish;
   end

   task automatic report_if_diff(input string what, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
      if (act_val !== exp_val) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch %s: expected 0x%0h, got 0x%0h", what, exp_val, act_val);
      end
   endtask

   // Advances the model by one event; returns 1 unless the event is ignored.
   function automatic bit decode_event(input logic cmd, input logic fall,
                                       input logic [TICK_W-1:0] ticks);
      ir_result_type res;
      bit applied;
      applied = 1'b1;
      if (cmd == CMD_TIMEOUT) begin
         applied = (ir_phase != PH_IDLE);
         if (ir_phase == PH_RECEIVING && ir_bit_count == '0) begin
            res.code_word = '0;
            res.is_repeat = 1'b1;
            expected_codes.push_back(res);
         end
         ir_phase = PH_IDLE;
      end else begin
         case (ir_phase)
            PH_IDLE: begin
               applied = fall;
               if (fall) begin
                  ir_phase = PH_LEADER;
                  ir_bit_count = '0;
                  ir_shift = '0;
               end
            end
            PH_LEADER: begin
               applied = (ticks > cfg_leader_min && ticks < cfg_leader_max);
               if (applied)
                  ir_phase = PH_FIRST_BIT;
            end
            PH_FIRST_BIT: begin
               ir_phase = PH_RECEIVING;
            end
            default: begin
               applied = fall;
               if (fall) begin
                  ir_shift = {ir_shift[SHIFT_W-2:0], ticks > cfg_one_space};
                  ir_bit_count++;
                  if (ir_bit_count >= CODE_BITS) begin
                     res.code_word = ir_shift[CODE_W-1:0];
                     res.is_repeat = 1'b0;
                     expected_codes.push_back(res);
                     ir_phase = PH_IDLE;
                  end
               end
            end
         endcase
      end
      return applied;
   endfunction

   // result checker
   always @(posedge clock) begin
      ir_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_codes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: code 0x%0h repeat %0b",
                        rsp_code_word, rsp_is_repeat);
         end else begin
            exp_res = expected_codes.pop_front();
            report_if_diff("code_word", exp_res.code_word, rsp_code_word);
            report_if_diff("is_repeat", exp_res.is_repeat, rsp_is_repeat);
         end
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (rsp_hold_req > 0) begin
         rsp_hold_left = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   task automatic send_event(input logic cmd, input logic fall, input logic [TICK_W-1:0] ticks);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_falling_edge   <= fall;
      req_interval_ticks <= ticks;
      do @(posedge clock); while (req_stall);
      if (decode_event(cmd, fall, ticks))
         events_applied++;
   endtask

   // drop valid, wait for every outstanding result, then let the pipe settle
   task automatic wait_quiet();
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_codes.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (guard >= DRAIN_LIMIT)
         report_if_diff("results outstanding", 0, expected_codes.size());
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_LEADER_MIN: cfg_leader_min = data[TICK_W-1:0];
         REG_LEADER_MAX: cfg_leader_max = data[TICK_W-1:0];
         REG_ONE_SPACE:  cfg_one_space  = data[TICK_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [1:0] idx, output logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_registers();
      logic [CSR_DATA_W-1:0] rd;
      csr_read(REG_LEADER_MIN, rd);
      report_if_diff("leader_min readback", cfg_leader_min, rd[TICK_W-1:0]);
      csr_read(REG_LEADER_MAX, rd);
      report_if_diff("leader_max readback", cfg_leader_max, rd[TICK_W-1:0]);
      csr_read(REG_ONE_SPACE, rd);
      report_if_diff("one_space readback", cfg_one_space, rd[TICK_W-1:0]);
   endtask

   // upper data bits are junk on purpose, the registers are 16 bits wide
   task automatic program_window(input logic [TICK_W-1:0] lmin, input logic [TICK_W-1:0] lmax,
                                 input logic [TICK_W-1:0] one);
      wait_quiet();
      csr_write(REG_LEADER_MIN, {16'($urandom), lmin});
      csr_write(REG_LEADER_MAX, {16'($urandom), lmax});
      csr_write(REG_ONE_SPACE,  {16'($urandom), one});
      check_registers();
   endtask

   function automatic logic rnd_bit();
      return 1'($urandom);
   endfunction

   function automatic logic [TICK_W-1:0] rnd_ticks();
      return TICK_W'($urandom_range(16'hFFFF));
   endfunction

   function automatic logic [TICK_W-1:0] leader_ticks();
      if (cfg_leader_max > cfg_leader_min + 17'd1)
         return TICK_W'($urandom_range(cfg_leader_max - 1, cfg_leader_min + 1));
      return rnd_ticks();
   endfunction

   // space lengths bunched around the one-bit threshold
   function automatic logic [TICK_W-1:0] bit_ticks();
      case ($urandom_range(3))
         0: return cfg_one_space;
         1: return (cfg_one_space == '1) ? cfg_one_space : cfg_one_space + 1'b1;
         2: return TICK_W'($urandom_range(cfg_one_space, 0));
         default: return TICK_W'($urandom_range(16'hFFFF, cfg_one_space));
      endcase
   endfunction

   task automatic send_frame(input int nbits, input bit end_timeout);
      int i;
      if (ir_phase != PH_IDLE)
         send_event(CMD_TIMEOUT, rnd_bit(), rnd_ticks());
      send_event(CMD_EDGE, 1'b1, rnd_ticks());
      // now and then a leader on the window boundary, which must not count
      if ($urandom_range(9) == 0)
         send_event(CMD_EDGE, rnd_bit(), rnd_bit() ? cfg_leader_min : cfg_leader_max);
      send_event(CMD_EDGE, rnd_bit(), leader_ticks());
      send_event(CMD_EDGE, rnd_bit(), rnd_ticks());
      for (i = 0; i < nbits; i++) begin
         if ($urandom_range(4) == 0)
            send_event(CMD_EDGE, 1'b0, rnd_ticks());
         send_event(CMD_EDGE, 1'b1, bit_ticks());
      end
      if (end_timeout)
         send_event(CMD_TIMEOUT, rnd_bit(), rnd_ticks());
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(6, 1);
      repeat (n)
         send_event(rnd_bit(), rnd_bit(), rnd_bit() ? leader_ticks() : rnd_ticks());
   endtask

   task automatic test_random_frames(input int count);
      int stop_at;
      int pick;
      bit window_open;
      stop_at = events_applied + count;
      while (events_applied < stop_at) begin
         pick = $urandom_range(99);
         window_open = (cfg_leader_max > cfg_leader_min + 17'd1);
         if (!window_open || pick >= 90)
            send_noise();
         else if (pick < 60)
            send_frame(CODE_BITS, 1'b0);
         else if (pick < 75)
            send_frame(0, 1'b1);
         else
            send_frame($urandom_range(CODE_BITS - 1, 1), 1'b1);
      end
   endtask

   task automatic test_special_cases();
      send_event(CMD_EDGE, 1'b0, 16'd500);      // rising edge in idle is ignored
      send_event(CMD_EDGE, 1'b1, 16'd0);        // opens a frame
      send_event(CMD_EDGE, 1'b1, LEADER_MIN_RST); // on the bounds: stays in leader
      send_event(CMD_EDGE, 1'b0, LEADER_MAX_RST);
      send_event(CMD_EDGE, 1'b0, 16'd2000);     // rising leader inside the window
      send_event(CMD_EDGE, 1'b0, 16'hFFFF);
      send_event(CMD_TIMEOUT, 1'b0, 16'd0);     // repeat marker
      send_event(CMD_EDGE, 1'b1, 16'hFFFF);
      send_event(CMD_EDGE, 1'b1, LEADER_MIN_RST + 16'd1);
      send_event(CMD_EDGE, 1'b1, 16'd0);
      send_event(CMD_TIMEOUT, 1'b1, 16'hFFFF);  // repeat marker
      send_event(CMD_TIMEOUT, 1'b0, 16'd123);   // timeout in idle
      send_event(CMD_EDGE, 1'b1, 16'd9000);
      send_event(CMD_EDGE, 1'b0, LEADER_MAX_RST - 16'd1);
      send_event(CMD_EDGE, 1'b1, 16'd4500);
      send_event(CMD_EDGE, 1'b1, ONE_SPACE_RST + 16'd1);
      send_event(CMD_EDGE, 1'b0, 16'd1000);     // rising edge while receiving
      send_event(CMD_EDGE, 1'b1, ONE_SPACE_RST);
      send_event(CMD_EDGE, 1'b1, 16'hFFFF);
      send_event(CMD_EDGE, 1'b1, 16'd0);
      send_event(CMD_TIMEOUT, 1'b1, 16'd77);    // bits received: no result
      send_event(CMD_EDGE, 1'b1, 16'd1);
      send_event(CMD_TIMEOUT, 1'b0, 16'h8000);  // timeout in leader
   endtask

   task automatic test_config_extremes();
      logic [CSR_DATA_W-1:0] junk;
      program_window(16'd0, 16'hFFFF, 16'd0);
      test_random_frames(30);
      program_window(16'hFFFF, 16'd0, 16'hFFFF);
      test_random_frames(25);
      program_window(16'd0, 16'd2, 16'hFFFF);
      test_random_frames(30);
      program_window(16'hFFFD, 16'hFFFF, 16'd1);
      test_random_frames(30);
      // a write past the last register must leave the others alone
      wait_quiet();
      junk = $urandom;
      csr_write(REG_UNUSED, junk);
      check_registers();
      test_random_frames(20);
   endtask

   task automatic test_random_window();
      logic [TICK_W-1:0] lmin;
      lmin = TICK_W'($urandom_range(3000, 100));
      program_window(lmin, lmin + TICK_W'($urandom_range(2000, 2)),
                     TICK_W'($urandom_range(2000, 50)));
      test_random_frames(120);
   endtask

   // receiver holds off while frames keep coming, so the input backs up
   task automatic test_output_backpressure();
      program_window(LEADER_MIN_RST, LEADER_MAX_RST, ONE_SPACE_RST);
      @(posedge clock);
      rsp_hold_req = 400;
      repeat (3)
         send_frame(CODE_BITS, 1'b0);
      wait_quiet();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_registers();
      send_idle_pct = 25;
      rcv_idle_pct  = 81;
      test_special_cases();
      test_random_frames(150);
      test_config_extremes();

      send_idle_pct = 81;
      rcv_idle_pct  = 25;
      test_random_window();

      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      test_output_backpressure();
      test_random_frames(100);

      wait_quiet();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[files.f]
design/nir_pkg.sv
design/nir_csr.sv
design/nir_decode.sv
design/nec_ir_frame_receiver_unit.sv
dv/tb.sv
